FILE: rtl/core/etb_pkg.sv
// Shared types and constants for the elimination tree builder.
package etb_pkg;

  localparam int unsigned MAX_ORDER   = 1024;
  localparam int unsigned IDX_W       = $clog2(MAX_ORDER);
  localparam int unsigned ORDER_W     = IDX_W + 1;
  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(MAX_ORDER);
  localparam logic [ORDER_W-1:0] ORDER_CAP   = ORDER_W'(MAX_ORDER);

  localparam logic STATUS_LINK  = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [ORDER_W-1:0] order_t;

  typedef struct packed {
    idx_t row_index;
    idx_t column_index;
    logic new_matrix;
  } in_item_t;

  typedef struct packed {
    logic status;
    idx_t child_node;
    idx_t parent_node;
  } out_item_t;

  // One ancestor store entry: valid flag and link to a higher node
  typedef struct packed {
    logic valid;
    idx_t link;
  } anc_entry_t;

  typedef struct packed {
    logic       en;
    idx_t       addr;
    anc_entry_t data;
  } anc_wr_t;

  typedef struct packed {
    logic en;
    idx_t addr;
  } anc_rd_t;

endpackage

FILE: rtl/core/etb_anc_mem.sv
// Ancestor store: one write port, one registered read port.
module etb_anc_mem (
  input  logic               clk,
  input  etb_pkg::anc_wr_t   wr,
  input  etb_pkg::anc_rd_t   rd,
  output etb_pkg::anc_entry_t rd_data
);

  etb_pkg::anc_entry_t mem [etb_pkg::MAX_ORDER];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

FILE: rtl/core/elimination_tree_builder_unit.sv
// Top level of the elimination tree builder: sequencer around the ancestor store.
//
// Usage: each input beat on in_valid/in_ready carries one off-diagonal entry
// (row_index, column_index, new_matrix), columns nondecreasing. For an entry
// with row below column the block walks the ancestor chain from the row,
// pointing every node passed at the column; if the walk ends on a node with
// no ancestor, one result beat {status 0, child, parent = column} is sent on
// out_valid/out_ready. An index at or above the order in force gives one
// result beat with status 1. In-range diagonal/lower entries give no beat.
// cfg_we/cfg_wdata write matrix_order; write it only while the block is idle.
//
// Sequence: each item is accepted (S_IDLE), range-checked (S_CHECK), then
// walked one node per cycle (one read-modify-write per cycle on the ancestor
// store), and a result is handed to the output register (S_EMIT). new_matrix
// adds a clearing sweep of all MAX_ORDER (1024) store entries before the
// entry is handled. Path compression keeps walks short.
// Reset: synchronous on rst_n low; afterwards the whole store is swept clear
// with in_ready low. A stalled receiver holds the result in the output
// register; a new item is still taken, and its own result waits until the
// output register frees up.
module elimination_tree_builder_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  etb_pkg::in_item_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output etb_pkg::out_item_t    out_data,
  input  logic                  cfg_we,
  input  etb_pkg::order_t       cfg_wdata
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic                pend_r, pend_nxt;        // item waits behind the sweep
  etb_pkg::idx_t       clr_cnt_r, clr_cnt_nxt;
  etb_pkg::idx_t       row_r, row_nxt;
  etb_pkg::idx_t       col_r, col_nxt;
  etb_pkg::idx_t       node_r, node_nxt;
  etb_pkg::out_item_t  res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  etb_pkg::out_item_t  out_data_r, out_data_nxt;
  etb_pkg::order_t     order_r;

  etb_pkg::anc_wr_t    wr;
  etb_pkg::anc_rd_t    rd;
  etb_pkg::anc_entry_t rd_data;

  etb_pkg::order_t     order_eff;
  logic                range_err;
  logic                accept;

  etb_anc_mem u_anc_mem (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  // Order in force: the smaller of the register and the store depth
  assign order_eff = (order_r < etb_pkg::ORDER_CAP) ? order_r : etb_pkg::ORDER_CAP;
  assign range_err = ({1'b0, row_r} >= order_eff) || ({1'b0, col_r} >= order_eff);

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= etb_pkg::ORDER_RESET;
    end else if (cfg_we) begin
      order_r <= cfg_wdata;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    clr_cnt_nxt   = clr_cnt_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    node_nxt      = node_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr            = '0;
    rd            = '0;

    // Drop the output beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        wr.en       = 1'b1;
        wr.addr     = clr_cnt_r;
        wr.data     = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = pend_r ? S_CHECK : S_IDLE;
          pend_nxt  = 1'b0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          row_nxt = in_data.row_index;
          col_nxt = in_data.column_index;
          if (in_data.new_matrix) begin
            pend_nxt    = 1'b1;
            clr_cnt_nxt = '0;
            state_nxt   = S_CLEAR;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (range_err) begin
          res_nxt   = '{status: etb_pkg::STATUS_RANGE, child_node: row_r, parent_node: col_r};
          state_nxt = S_EMIT;
        end else if (row_r >= col_r) begin
          state_nxt = S_IDLE;
        end else begin
          rd.en     = 1'b1;
          rd.addr   = row_r;
          node_nxt  = row_r;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        // Point the node at the column, then follow its old link
        wr.en        = 1'b1;
        wr.addr      = node_r;
        wr.data      = '{valid: 1'b1, link: col_r};
        if (!rd_data.valid) begin
          res_nxt   = '{status: etb_pkg::STATUS_LINK, child_node: node_r, parent_node: col_r};
          state_nxt = S_EMIT;
        end else if (rd_data.link >= col_r) begin
          state_nxt = S_IDLE;
        end else begin
          rd.en    = 1'b1;
          rd.addr  = rd_data.link;
          node_nxt = rd_data.link;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pend_r      <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    node_r     <= node_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // The walk only ever rewrites nodes below the current column
  a_walk_below_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (node_r < col_r))
    else $error("walk reached a node at or above the column");

  // A parent link always points upward
  a_link_upward: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == etb_pkg::STATUS_LINK) |->
      (out_data_r.child_node < out_data_r.parent_node))
    else $error("parent link does not point to a higher node");

  // One item at a time: no second beat right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input taken while an item is in progress");

  // The sweep runs through the whole store without a break
  a_sweep_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && state_r == S_CLEAR && clr_cnt_r != '1) |=>
      (state_r == S_CLEAR && clr_cnt_r == $past(clr_cnt_r) + 1'b1))
    else $error("clearing sweep broken off");

endmodule
